[sv/pcp_pkg.sv]
`default_nettype none

package pcp_pkg;

  localparam int unsigned COORD_BITS_DEFAULT = 12;
  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned NUM_FACES = 2 * NUM_AXES;
  localparam int unsigned NUM_REGS = 5;

  localparam int unsigned SIGMA_W = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned RATIO_BITS = 18;
  localparam int unsigned RATIO_INT_BITS = RATIO_BITS - FRAC_BITS;
  localparam logic [RATIO_BITS-1:0] RATIO_MAX = '1;
  localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1 << FRAC_BITS);
  localparam logic [SIGMA_W-1:0] SIGMA_MAX = '1;

  localparam int unsigned ORDER_W = 4;
  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(2);
  localparam int unsigned POW_STAGES = (1 << ORDER_W) - 1;

  localparam int unsigned DIV_STEPS = 3;
  localparam int unsigned DIV_STAGES = RATIO_BITS / DIV_STEPS;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned REG_IDX_W = 3;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_INTERIOR_LOW,
    REG_INTERIOR_HIGH,
    REG_GRADING_ORDER,
    REG_PEAK_XY,
    REG_PEAK_Z
  } reg_idx_t;

  // Per-face classification made at the front
  typedef struct packed {
    logic active;
    logic zero_thick;
    logic over;
  } face_class_t;

  function automatic logic [SIGMA_W-1:0] sat_add(input logic [SIGMA_W-1:0] a,
                                                 input logic [SIGMA_W-1:0] b);
    logic [SIGMA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SIGMA_W] ? SIGMA_MAX : s[SIGMA_W-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/pml_conductivity_profile_top.sv]
`default_nettype none

// Channel   Dir  Transfer when              Payload
// cfg       in   psel&penable&pwrite&pready  pwdata -> register at paddr (8-byte stride)
// s_axis    in   s_tvalid & s_tready         s_tdata: voxel_x, voxel_y, voxel_z
// m_axis    out  m_tvalid & m_tready         m_tdata: pml_sigma (Q16.16)
//
// One voxel per cycle sustained while m_axis is not stalled. The back pipeline holds the
// 6-stage divider (3 quotient bits per stage), 15 power stages (one multiplier each)
// and the scaling and summing stages.
// Reset clears all valid flags and loads register reset values (grading_order = 2).
// A stall on m_axis freezes the back pipeline; the front and its 4-entry queue keep
// taking voxels until the queue fills.

module pml_conductivity_profile_top #(
  parameter int unsigned COORD_BITS = pcp_pkg::COORD_BITS_DEFAULT,
  localparam int unsigned BOX_W = pcp_pkg::NUM_AXES * COORD_BITS,
  localparam int unsigned S_TDATA_W = ((BOX_W + 7) / 8) * 8,
  localparam int unsigned APB_DW = (BOX_W > 32) ? 64 : 32,
  localparam int unsigned REG_STRIDE = APB_DW / 8,
  localparam int unsigned ADDR_W = $clog2(pcp_pkg::NUM_REGS * REG_STRIDE)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]          prdata,
  output logic                       pready,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // voxel_x, voxel_y, voxel_z from bit 0 up, zero padded
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // pml_sigma
  output logic [pcp_pkg::SIGMA_W-1:0] m_tdata
);

  localparam int unsigned NF = pcp_pkg::NUM_FACES;
  localparam int unsigned ITEM_W = NF * ($bits(pcp_pkg::face_class_t) + COORD_BITS);

  logic [BOX_W-1:0] interior_low;
  logic [BOX_W-1:0] interior_high;
  logic [pcp_pkg::ORDER_W-1:0] grading_order;
  logic [pcp_pkg::SIGMA_W-1:0] peak_sigma_xy;
  logic [pcp_pkg::SIGMA_W-1:0] peak_sigma_z;
  pcp_pkg::reg_idx_t reg_idx;
  logic cfg_write;

  logic [COORD_BITS-1:0] xl;
  logic [COORD_BITS-1:0] zl;
  logic [COORD_BITS-1:0] thick_xy;
  logic [COORD_BITS-1:0] thick_z;

  logic f_valid;
  logic f_ready;
  pcp_pkg::face_class_t [NF-1:0] f_class;
  logic [NF-1:0][COORD_BITS-1:0] f_depth;
  logic q_valid;
  logic q_ready;
  logic [ITEM_W-1:0] q_data;
  pcp_pkg::face_class_t [NF-1:0] b_class;
  logic [NF-1:0][COORD_BITS-1:0] b_depth;

  assign pready    = 1'b1;
  assign reg_idx   = pcp_pkg::reg_idx_t'(paddr[ADDR_W-1 -: pcp_pkg::REG_IDX_W]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      interior_low  <= '0;
      interior_high <= '0;
      grading_order <= pcp_pkg::ORDER_RESET;
      peak_sigma_xy <= '0;
      peak_sigma_z  <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        pcp_pkg::REG_INTERIOR_LOW:  interior_low  <= pwdata[BOX_W-1:0];
        pcp_pkg::REG_INTERIOR_HIGH: interior_high <= pwdata[BOX_W-1:0];
        pcp_pkg::REG_GRADING_ORDER: grading_order <= pwdata[pcp_pkg::ORDER_W-1:0];
        pcp_pkg::REG_PEAK_XY:       peak_sigma_xy <= pwdata[pcp_pkg::SIGMA_W-1:0];
        pcp_pkg::REG_PEAK_Z:        peak_sigma_z  <= pwdata[pcp_pkg::SIGMA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pcp_pkg::REG_INTERIOR_LOW:  prdata = APB_DW'(interior_low);
      pcp_pkg::REG_INTERIOR_HIGH: prdata = APB_DW'(interior_high);
      pcp_pkg::REG_GRADING_ORDER: prdata = APB_DW'(grading_order);
      pcp_pkg::REG_PEAK_XY:       prdata = APB_DW'(peak_sigma_xy);
      pcp_pkg::REG_PEAK_Z:        prdata = APB_DW'(peak_sigma_z);
      default:                    prdata = '0;
    endcase
  end

  // layer thickness is the low bound minus one, clamped at zero
  assign xl = interior_low[0 +: COORD_BITS];
  assign zl = interior_low[(pcp_pkg::NUM_AXES-1)*COORD_BITS +: COORD_BITS];
  assign thick_xy = (xl == '0) ? '0 : xl - COORD_BITS'(1);
  assign thick_z  = (zl == '0) ? '0 : zl - COORD_BITS'(1);

  pcp_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .interior_low (interior_low),
    .interior_high(interior_high),
    .thick_xy     (thick_xy),
    .thick_z      (thick_z),
    .out_valid    (f_valid),
    .out_ready    (f_ready),
    .out_class    (f_class),
    .out_depth    (f_depth)
  );

  pcp_queue #(
    .WIDTH(ITEM_W),
    .DEPTH(pcp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_data  ({f_class, f_depth}),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_data (q_data)
  );

  assign {b_class, b_depth} = q_data;

  pcp_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_ready     (q_ready),
    .in_class     (b_class),
    .in_depth     (b_depth),
    .thick_xy     (thick_xy),
    .thick_z      (thick_z),
    .grading_order(grading_order),
    .peak_sigma_xy(peak_sigma_xy),
    .peak_sigma_z (peak_sigma_z),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

endmodule

`default_nettype wire

[sv/pcp_front.sv]
`default_nettype none

module pcp_front #(
  parameter int unsigned COORD_BITS = pcp_pkg::COORD_BITS_DEFAULT,
  localparam int unsigned BOX_W = pcp_pkg::NUM_AXES * COORD_BITS,
  localparam int unsigned S_TDATA_W = ((BOX_W + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  input  wire logic [BOX_W-1:0]      interior_low,
  input  wire logic [BOX_W-1:0]      interior_high,
  input  wire logic [COORD_BITS-1:0] thick_xy,
  input  wire logic [COORD_BITS-1:0] thick_z,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output pcp_pkg::face_class_t [pcp_pkg::NUM_FACES-1:0] out_class,
  output logic [pcp_pkg::NUM_FACES-1:0][COORD_BITS-1:0] out_depth
);

  localparam int unsigned IB = pcp_pkg::RATIO_INT_BITS;

  pcp_pkg::face_class_t [pcp_pkg::NUM_FACES-1:0] class_next;
  logic [pcp_pkg::NUM_FACES-1:0][COORD_BITS-1:0] depth_next;

  always_comb begin
    logic [COORD_BITS-1:0] v;
    logic [COORD_BITS-1:0] lo;
    logic [COORD_BITS-1:0] hi;
    logic [COORD_BITS-1:0] t;
    for (int a = 0; a < pcp_pkg::NUM_AXES; a++) begin
      v  = s_tdata[a*COORD_BITS +: COORD_BITS];
      lo = interior_low[a*COORD_BITS +: COORD_BITS];
      hi = interior_high[a*COORD_BITS +: COORD_BITS];
      t  = (a == pcp_pkg::NUM_AXES - 1) ? thick_z : thick_xy;
      class_next[2*a].active   = v < lo;
      depth_next[2*a]          = lo - v;
      class_next[2*a+1].active = v > hi;
      depth_next[2*a+1]        = v - hi;
      for (int s = 0; s < 2; s++) begin
        class_next[2*a+s].zero_thick = (t == '0);
        // ratio reaches the Q2.16 ceiling once depth >= 4 * thickness
        class_next[2*a+s].over = {{IB{1'b0}}, depth_next[2*a+s]} >= {t, {IB{1'b0}}};
      end
    end
  end

  assign s_tready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_tready) begin
      out_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      out_class <= class_next;
      out_depth <= depth_next;
    end
  end

endmodule

`default_nettype wire

[sv/pcp_queue.sv]
`default_nettype none

module pcp_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = pcp_pkg::QUEUE_DEPTH,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data
);

  logic [DEPTH-1:0][WIDTH-1:0] mem;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic push;
  logic pop;

  assign in_ready  = count != CNT_W'(DEPTH);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

[sv/pcp_back.sv]
`default_nettype none

module pcp_back #(
  parameter int unsigned COORD_BITS = pcp_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire pcp_pkg::face_class_t [pcp_pkg::NUM_FACES-1:0] in_class,
  input  wire logic [pcp_pkg::NUM_FACES-1:0][COORD_BITS-1:0] in_depth,
  input  wire logic [COORD_BITS-1:0] thick_xy,
  input  wire logic [COORD_BITS-1:0] thick_z,
  input  wire logic [pcp_pkg::ORDER_W-1:0] grading_order,
  input  wire logic [pcp_pkg::SIGMA_W-1:0] peak_sigma_xy,
  input  wire logic [pcp_pkg::SIGMA_W-1:0] peak_sigma_z,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [pcp_pkg::SIGMA_W-1:0] m_tdata
);

  localparam int unsigned NF = pcp_pkg::NUM_FACES;
  localparam int unsigned RB = pcp_pkg::RATIO_BITS;
  localparam int unsigned FB = pcp_pkg::FRAC_BITS;
  localparam int unsigned IB = pcp_pkg::RATIO_INT_BITS;
  localparam int unsigned SW = pcp_pkg::SIGMA_W;
  localparam int unsigned DS = pcp_pkg::DIV_STAGES;
  localparam int unsigned PS = pcp_pkg::POW_STAGES;
  localparam int unsigned OW = pcp_pkg::ORDER_W;
  // x and y faces come first, z faces last
  localparam int unsigned Z_FACE0 = NF - 2;

  function automatic logic [RB-1:0] ratio_mul(input logic [RB-1:0] a,
                                              input logic [RB-1:0] b);
    logic [2*RB-1:0] prod;
    prod = a * b;
    return (prod[2*RB-1 -: IB] != '0) ? pcp_pkg::RATIO_MAX : prod[FB +: RB];
  endfunction

  logic adv;

  // divider stages: restoring, DIV_STEPS quotient bits per stage
  logic [DS-1:0] dv;
  pcp_pkg::face_class_t [DS-1:0][NF-1:0] dcls;
  pcp_pkg::face_class_t [DS-1:0][NF-1:0] dcls_in;
  logic [DS-1:0][NF-1:0][COORD_BITS-1:0] drem, drem_in, drem_next;
  logic [DS-1:0][NF-1:0][RB-1:0] dquo, dquo_in, dquo_next;

  // power stages: one multiply by the ratio per stage below grading_order
  logic [PS-1:0] pv;
  pcp_pkg::face_class_t [PS-1:0][NF-1:0] pcls, pcls_in;
  logic [PS-1:0][NF-1:0][RB-1:0] pratio, pratio_in;
  logic [PS-1:0][NF-1:0][RB-1:0] ppow, ppow_in, ppow_next;

  logic tv;
  logic [NF-1:0][SW-1:0] term, term_next;
  logic av;
  logic [pcp_pkg::NUM_AXES-1:0][SW-1:0] axis_sum;
  logic bv;
  logic [SW-1:0] sum_xy;
  logic [SW-1:0] sum_z;

  assign adv = !m_tvalid || m_tready;
  assign in_ready = adv;

  for (genvar s = 0; s < DS; s++) begin : g_div_src
    if (s == 0) begin : g_first
      always_comb begin
        for (int f = 0; f < NF; f++) begin
          dcls_in[0][f] = in_class[f];
          drem_in[0][f] = COORD_BITS'(in_depth[f] >> IB);
          dquo_in[0][f] = {in_depth[f][IB-1:0], {FB{1'b0}}};
        end
      end
    end else begin : g_rest
      assign dcls_in[s] = dcls[s-1];
      assign drem_in[s] = drem[s-1];
      assign dquo_in[s] = dquo[s-1];
    end
  end

  always_comb begin
    logic [COORD_BITS-1:0] r;
    logic [RB-1:0] q;
    logic [COORD_BITS:0] r2;
    logic [COORD_BITS-1:0] t;
    logic ge;
    for (int s = 0; s < DS; s++) begin
      for (int f = 0; f < NF; f++) begin
        t = (f >= Z_FACE0) ? thick_z : thick_xy;
        r = drem_in[s][f];
        q = dquo_in[s][f];
        for (int k = 0; k < pcp_pkg::DIV_STEPS; k++) begin
          r2 = {r, q[RB-1]};
          ge = r2 >= {1'b0, t};
          q  = {q[RB-2:0], ge};
          r  = ge ? COORD_BITS'(r2 - {1'b0, t}) : r2[COORD_BITS-1:0];
        end
        drem_next[s][f] = r;
        dquo_next[s][f] = q;
      end
    end
  end

  for (genvar n = 0; n < PS; n++) begin : g_pow_src
    if (n == 0) begin : g_first
      always_comb begin
        for (int f = 0; f < NF; f++) begin
          pcls_in[0][f]   = dcls[DS-1][f];
          pratio_in[0][f] = dcls[DS-1][f].over ? pcp_pkg::RATIO_MAX : dquo[DS-1][f];
          ppow_in[0][f]   = pcp_pkg::RATIO_ONE;
        end
      end
    end else begin : g_rest
      assign pcls_in[n]   = pcls[n-1];
      assign pratio_in[n] = pratio[n-1];
      assign ppow_in[n]   = ppow[n-1];
    end
    always_comb begin
      for (int f = 0; f < NF; f++) begin
        ppow_next[n][f] = (OW'(n) < grading_order)
                          ? ratio_mul(ppow_in[n][f], pratio_in[n][f])
                          : ppow_in[n][f];
      end
    end
  end

  always_comb begin
    logic [SW+RB-1:0] prod;
    logic [SW-1:0] peak;
    for (int f = 0; f < NF; f++) begin
      peak = (f >= Z_FACE0) ? peak_sigma_z : peak_sigma_xy;
      prod = peak * ppow[PS-1][f];
      if (!pcls[PS-1][f].active) begin
        term_next[f] = '0;
      end else if (pcls[PS-1][f].zero_thick || prod[SW+RB-1 -: IB] != '0) begin
        term_next[f] = pcp_pkg::SIGMA_MAX;
      end else begin
        term_next[f] = prod[FB +: SW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv       <= '0;
      pv       <= '0;
      tv       <= 1'b0;
      av       <= 1'b0;
      bv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      dv       <= {dv[DS-2:0], in_valid};
      pv       <= {pv[PS-2:0], dv[DS-1]};
      tv       <= pv[PS-1];
      av       <= tv;
      bv       <= av;
      m_tvalid <= bv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dcls   <= dcls_in;
      drem   <= drem_next;
      dquo   <= dquo_next;
      pcls   <= pcls_in;
      pratio <= pratio_in;
      ppow   <= ppow_next;
      term   <= term_next;
      for (int a = 0; a < pcp_pkg::NUM_AXES; a++) begin
        axis_sum[a] <= pcp_pkg::sat_add(term[2*a], term[2*a+1]);
      end
      sum_xy  <= pcp_pkg::sat_add(axis_sum[0], axis_sum[1]);
      sum_z   <= axis_sum[pcp_pkg::NUM_AXES-1];
      m_tdata <= pcp_pkg::sat_add(sum_xy, sum_z);
    end
  end

endmodule

`default_nettype wire

[sv/pcp_checker.sv]
`default_nettype none

module pcp_checker #(
  parameter int unsigned COORD_BITS = pcp_pkg::COORD_BITS_DEFAULT,
  localparam int unsigned BOX_W = pcp_pkg::NUM_AXES * COORD_BITS,
  localparam int unsigned APB_DW = (BOX_W > 32) ? 64 : 32,
  localparam int unsigned REG_STRIDE = APB_DW / 8,
  localparam int unsigned ADDR_W = $clog2(pcp_pkg::NUM_REGS * REG_STRIDE)
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic [ADDR_W-1:0]     paddr,
  input wire logic [APB_DW-1:0]     prdata,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [pcp_pkg::SIGMA_W-1:0] m_tdata
);

  localparam logic [ADDR_W-1:0] ORDER_ADDR =
    ADDR_W'(int'(pcp_pkg::REG_GRADING_ORDER) * REG_STRIDE);

  logic [7:0] outstanding;
  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_xfer && !out_xfer) begin
      outstanding <= outstanding + 8'd1;
    end else if (out_xfer && !in_xfer) begin
      outstanding <= outstanding - 8'd1;
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> (!m_tvalid && s_tready))
    else $error("pipeline not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (outstanding != 8'd0))
    else $error("result without a pending voxel");

  a_order_reset: assert property (@(posedge clk)
    ($past(rst) && paddr == ORDER_ADDR) |-> (prdata == APB_DW'(pcp_pkg::ORDER_RESET)))
    else $error("grading order reset value wrong");

endmodule

bind pml_conductivity_profile_top pcp_checker #(.COORD_BITS(COORD_BITS)) u_pcp_checker (.*);

`default_nettype wire

[tb/sv/tb_pml_conductivity_profile_top.sv]
`default_nettype none

module tb_pml_conductivity_profile_top;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned BOX_W = 3 * COORD_W;
  localparam int unsigned VOXEL_W = 40;
  localparam int unsigned APB_W = 64;
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned REG_BYTES = 8;
  localparam int unsigned UNMAPPED_REG = pcp_pkg::NUM_REGS;
  localparam int unsigned PIPE_LATENCY = 26;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SIGMA_W = pcp_pkg::SIGMA_W;
  localparam int unsigned ORDER_W = pcp_pkg::ORDER_W;
  localparam int unsigned FRAC_BITS = pcp_pkg::FRAC_BITS;
  localparam logic [SIGMA_W-1:0] SIGMA_MAX = pcp_pkg::SIGMA_MAX;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [APB_W-1:0]   pwdata = '0;
  logic [APB_W-1:0]   prdata;
  logic               pready;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [VOXEL_W-1:0] s_tdata = '0;  // voxel_x, voxel_y, voxel_z from bit 0 up, zero padded
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [SIGMA_W-1:0] m_tdata;       // pml_sigma

  pml_conductivity_profile_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the profile registers
  logic [BOX_W-1:0]   box_lo = '0;
  logic [BOX_W-1:0]   box_hi = '0;
  logic [ORDER_W-1:0] order_cfg = pcp_pkg::ORDER_RESET;
  logic [SIGMA_W-1:0] peak_xy_cfg = '0;
  logic [SIGMA_W-1:0] peak_z_cfg = '0;

  logic [VOXEL_W-1:0] voxel_q[$];
  logic [SIGMA_W-1:0] sigma_q[$];
  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count = 0;
  int unsigned        send_gap = 0;
  int unsigned        take_wait = 0;
  bit                 steady_flow = 1'b0;
  logic               in_fire = 1'b0;
  logic               out_fire = 1'b0;

  function automatic logic [SIGMA_W-1:0] clip_sum(input logic [SIGMA_W-1:0] a,
                                                  input logic [SIGMA_W-1:0] b);
    logic [SIGMA_W:0] s;
    s = (SIGMA_W+1)'(a) + (SIGMA_W+1)'(b);
    return (s > (SIGMA_W+1)'(SIGMA_MAX)) ? SIGMA_MAX : s[SIGMA_W-1:0];
  endfunction

  // peak * (depth / thick)^order, truncated and saturated at each step
  function automatic logic [SIGMA_W-1:0] face_sigma(input logic [COORD_W-1:0] depth,
                                                    input logic [COORD_W-1:0] thick,
                                                    input logic [SIGMA_W-1:0] peak);
    logic [63:0] ratio;
    logic [63:0] power;
    logic [63:0] scaled;
    if (thick == '0) return SIGMA_MAX;
    ratio = (64'(depth) << FRAC_BITS) / 64'(thick);
    if (ratio > 64'(pcp_pkg::RATIO_MAX)) ratio = 64'(pcp_pkg::RATIO_MAX);
    power = 64'(pcp_pkg::RATIO_ONE);
    repeat (order_cfg) begin
      power = (power * ratio) >> FRAC_BITS;
      if (power > 64'(pcp_pkg::RATIO_MAX)) power = 64'(pcp_pkg::RATIO_MAX);
    end
    scaled = (64'(peak) * power) >> FRAC_BITS;
    return (scaled > 64'(SIGMA_MAX)) ? SIGMA_MAX : scaled[SIGMA_W-1:0];
  endfunction

  function automatic logic [SIGMA_W-1:0] face_pair(input logic [COORD_W-1:0] v,
                                                   input logic [COORD_W-1:0] lo,
                                                   input logic [COORD_W-1:0] hi,
                                                   input logic [COORD_W-1:0] thick,
                                                   input logic [SIGMA_W-1:0] peak);
    logic [SIGMA_W-1:0] acc;
    acc = '0;
    if (v < lo) acc = clip_sum(acc, face_sigma(lo - v, thick, peak));
    if (v > hi) acc = clip_sum(acc, face_sigma(v - hi, thick, peak));
    return acc;
  endfunction

  function automatic logic [SIGMA_W-1:0] sigma_of_voxel(input logic [VOXEL_W-1:0] d);
    logic [COORD_W-1:0] xl;
    logic [COORD_W-1:0] zl;
    logic [COORD_W-1:0] thick_xy;
    logic [COORD_W-1:0] thick_z;
    logic [SIGMA_W-1:0] sum;
    xl = box_lo[0 +: COORD_W];
    zl = box_lo[2*COORD_W +: COORD_W];
    // a low bound of zero clamps the thickness to zero
    thick_xy = (xl == '0) ? '0 : xl - COORD_W'(1);
    thick_z = (zl == '0) ? '0 : zl - COORD_W'(1);
    sum = face_pair(d[0 +: COORD_W], xl, box_hi[0 +: COORD_W], thick_xy, peak_xy_cfg);
    sum = clip_sum(sum, face_pair(d[COORD_W +: COORD_W], box_lo[COORD_W +: COORD_W],
                                  box_hi[COORD_W +: COORD_W], thick_xy, peak_xy_cfg));
    sum = clip_sum(sum, face_pair(d[2*COORD_W +: COORD_W], zl,
                                  box_hi[2*COORD_W +: COORD_W], thick_z, peak_z_cfg));
    return sum;
  endfunction

  function automatic logic [BOX_W-1:0] pack_box(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic [COORD_W-1:0] z);
    return {z, y, x};
  endfunction

  // Bias coordinates toward the faces of the box
  function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] lo,
                                                    input logic [COORD_W-1:0] hi);
    logic [COORD_W-1:0] c;
    case ($urandom_range(0, 5))
      0: c = COORD_W'($urandom);
      1: c = lo - COORD_W'($urandom_range(0, 40));
      2: c = hi + COORD_W'($urandom_range(0, 40));
      3: c = lo + COORD_W'($urandom_range(0, 3));
      4: c = hi - COORD_W'($urandom_range(0, 3));
      default: c = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [SIGMA_W-1:0] got,
                                 input logic [SIGMA_W-1:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic write_reg(input int unsigned idx, input logic [APB_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * REG_BYTES);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      pcp_pkg::REG_INTERIOR_LOW:  box_lo = val[BOX_W-1:0];
      pcp_pkg::REG_INTERIOR_HIGH: box_hi = val[BOX_W-1:0];
      pcp_pkg::REG_GRADING_ORDER: order_cfg = val[ORDER_W-1:0];
      pcp_pkg::REG_PEAK_XY:       peak_xy_cfg = val[SIGMA_W-1:0];
      pcp_pkg::REG_PEAK_Z:        peak_z_cfg = val[SIGMA_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (voxel_q.size() != 0 || s_tvalid || sigma_q.size() != 0) @(posedge clk);
  endtask

  task automatic program_profile(input logic [BOX_W-1:0] lo, input logic [BOX_W-1:0] hi,
                                 input logic [ORDER_W-1:0] ord,
                                 input logic [SIGMA_W-1:0] pxy,
                                 input logic [SIGMA_W-1:0] pz);
    wait_drained();
    write_reg(pcp_pkg::REG_INTERIOR_LOW, APB_W'(lo));
    write_reg(pcp_pkg::REG_INTERIOR_HIGH, APB_W'(hi));
    write_reg(pcp_pkg::REG_GRADING_ORDER, APB_W'(ord));
    write_reg(pcp_pkg::REG_PEAK_XY, APB_W'(pxy));
    write_reg(pcp_pkg::REG_PEAK_Z, APB_W'(pz));
  endtask

  task automatic push_voxel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z);
    voxel_q = {voxel_q, VOXEL_W'(pack_box(x, y, z))};
  endtask

  task automatic random_phase(input int unsigned n_items, input bit steady,
                              input bit pause_midway);
    logic [COORD_W-1:0] lo_c[3];
    logic [COORD_W-1:0] hi_c[3];
    logic [ORDER_W-1:0] ord;
    logic [SIGMA_W-1:0] pxy;
    logic [SIGMA_W-1:0] pz;
    for (int a = 0; a < 3; a++) begin
      lo_c[a] = ($urandom_range(0, 4) == 0) ? COORD_W'($urandom)
                                            : COORD_W'($urandom_range(0, 80));
      hi_c[a] = ($urandom_range(0, 4) == 0) ? COORD_W'($urandom)
                                            : lo_c[a] + COORD_W'($urandom_range(0, 400));
    end
    ord = ($urandom_range(0, 3) == 0) ? ORDER_W'($urandom) : ORDER_W'($urandom_range(0, 8));
    pxy = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000);
    pz = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000);
    program_profile(pack_box(lo_c[0], lo_c[1], lo_c[2]), pack_box(hi_c[0], hi_c[1], hi_c[2]),
                    ord, pxy, pz);
    steady_flow = steady;
    for (int k = 0; k < n_items; k++) begin
      // hold the sender until the pipeline has emptied
      if (pause_midway && k == n_items / 2) wait_drained();
      push_voxel(pick_coord(lo_c[0], hi_c[0]), pick_coord(lo_c[1], hi_c[1]),
                 pick_coord(lo_c[2], hi_c[2]));
    end
  endtask

  // Voxel driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (send_gap != 0) begin
        s_tvalid <= 1'b0;
        send_gap--;
      end else if (voxel_q.size() != 0) begin
        s_tdata <= voxel_q.pop_front();
        s_tvalid <= 1'b1;
        send_gap = steady_flow ? 0 : $urandom_range(0, 3);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result sink with random back-pressure
  always @(negedge clk) begin
    if (out_fire) take_wait = steady_flow ? 0 : $urandom_range(0, 3);
    if (rst) begin
      m_tready <= 1'b0;
    end else if (take_wait != 0) begin
      m_tready <= 1'b0;
      take_wait--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    logic [SIGMA_W-1:0] want;
    in_fire <= s_tvalid && s_tready && !rst;
    out_fire <= m_tvalid && m_tready && !rst;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (sigma_q.size() == 0) begin
          report_mismatch("unexpected pml_sigma", m_tdata, '0);
        end else begin
          want = sigma_q.pop_front();
          if (m_tdata !== want) report_mismatch("pml_sigma", m_tdata, want);
        end
      end
      if (s_tvalid && s_tready) sigma_q = {sigma_q, sigma_of_voxel(s_tdata)};
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL pml_conductivity_profile_top");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset profile: zero low bound clamps thickness, so any outside face saturates
    push_voxel(12'd0, 12'd0, 12'd0);
    push_voxel(12'd1, 12'd0, 12'd0);
    push_voxel(12'd0, 12'd0, 12'd4095);

    program_profile(pack_box(12'd10, 12'd10, 12'd8), pack_box(12'd100, 12'd200, 12'd50),
                    4'd2, 32'h0002_0000, 32'h0001_8000);
    push_voxel(12'd50, 12'd50, 12'd20);
    push_voxel(12'd10, 12'd10, 12'd8);
    push_voxel(12'd100, 12'd200, 12'd50);
    push_voxel(12'd9, 12'd50, 12'd20);
    push_voxel(12'd0, 12'd0, 12'd0);
    push_voxel(12'd4095, 12'd4095, 12'd4095);
    push_voxel(12'd101, 12'd201, 12'd51);
    push_voxel(12'd5, 12'd250, 12'd3);

    // low bound of one: zero thickness; order zero gives the bare peak
    program_profile(pack_box(12'd1, 12'd1, 12'd1), pack_box(12'd4094, 12'd4094, 12'd4094),
                    4'd0, SIGMA_MAX, SIGMA_MAX);
    push_voxel(12'd0, 12'd100, 12'd100);
    push_voxel(12'd2, 12'd2, 12'd2);

    // inverted box: both faces of an axis can add
    program_profile(pack_box(12'd200, 12'd300, 12'd100), pack_box(12'd50, 12'd60, 12'd40),
                    4'd15, SIGMA_MAX, 32'h0000_0001);
    write_reg(UNMAPPED_REG, '1);
    push_voxel(12'd100, 12'd100, 12'd70);
    push_voxel(12'd4095, 12'd0, 12'd4095);
    push_voxel(12'd0, 12'd4095, 12'd0);

    program_profile('1, '1, 4'd8, 32'h1234_5678, 32'h0000_FFFF);
    push_voxel(12'd0, 12'd0, 12'd0);
    push_voxel(12'd4095, 12'd4095, 12'd4095);
    push_voxel(12'd4094, 12'd0, 12'd4000);

    for (int p = 0; p < 16; p++) random_phase(120, (p % 4) == 1, p == 3);

    wait_drained();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS pml_conductivity_profile_top");
    end else begin
      $display("FAIL pml_conductivity_profile_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
